>>> design/ffba_pkg.sv
// Shared constants, codes and types of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int WORD_W       = 32;
  localparam int CFG_IDX_W    = 1;

  // request kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_RESIZE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_SPACE   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  // table write sources
  localparam logic [1:0] WR_FIT    = 2'd0;
  localparam logic [1:0] WR_OLD    = 2'd1;
  localparam logic [1:0] WR_APPEND = 2'd2;

  // result word sources
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_ALLOC = 2'd1;
  localparam logic [1:0] SRC_SAME  = 2'd2;
  localparam logic [1:0] SRC_MOVED = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] bytes;
    logic              is_free;
  } entry_t;

  typedef struct packed {
    logic       in_load;
    logic       scan_start;
    logic       scan_en;
    logic       scan_fit;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       out_load;
    logic [1:0] out_status;
    logic [1:0] out_src;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       addr_zero;
    logic       size_zero;
    logic       scan_hit;
    logic       scan_miss;
    logic       old_fits;
    logic       app_fail;
  } sts_t;

endpackage

>>> design/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   Request channel (in_valid_i / in_ready_o) carries one word per request:
//   kind_i (allocate, free, resize), request_size_i and payload_address_i.
//   Result channel (out_valid_o / out_ready_i) returns exactly one word per
//   request: status_o, result_address_o, moved_o and copy_bytes_o.
//   Config channel (cfg_valid_i / cfg_ready_o) writes heap_base (index 0)
//   or heap_limit (index 1); write it only while no request is in flight.
// Sequencing: one request at a time. Each table scan walks the block table
//   through the registered memory read port at one entry per cycle, up to
//   the block count; a resize that moves runs two scans.
// Reset: the table is empty, the break follows heap_base, heap_base is 0
//   and heap_limit is all ones. The table memory needs no clearing pass:
//   only entries below the block count are ever read.
// Stall: the result register holds its word while out_ready_i is low; the
//   next request is still taken and worked on, and it waits only for the
//   result register to drain before delivering its own word.

module first_fit_block_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ffba_pkg::WORD_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         kind_i,
  input  logic [ffba_pkg::WORD_W-1:0]        request_size_i,
  input  logic [ffba_pkg::WORD_W-1:0]        payload_address_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [ffba_pkg::WORD_W-1:0]        result_address_o,
  output logic                               moved_o,
  output logic [ffba_pkg::WORD_W-1:0]        copy_bytes_o
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  // config writes land directly in the base and limit registers, so always take them
  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffba_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .request_size_i    (request_size_i),
    .payload_address_i (payload_address_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .result_address_o  (result_address_o),
    .moved_o           (moved_o),
    .copy_bytes_o      (copy_bytes_o)
  );

`ifndef SYNTH
  // a failed request never hands back an address or a copy length
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ffba_pkg::ST_OK)) |->
      ((result_address_o == '0) && !moved_o && (copy_bytes_o == '0)))
    else $error("failed result carries nonzero fields");

  // a move only follows a successful allocation of a new block
  a_moved_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && moved_o) |-> (status_o == ffba_pkg::ST_OK))
    else $error("moved flag on a failed result");

  // the block is busy in the cycle after it takes a request
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is in flight");

  // a scan cannot both hit and run off the end of the table
  a_scan_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.scan_hit |-> !sts.scan_miss)
    else $error("scan reports hit and miss together");
`endif

endmodule

>>> design/ffba_dpath.sv
// Datapath: block table memory, scan pipeline, break and result registers.
`timescale 1ns / 1ps

module ffba_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ffba_pkg::WORD_W-1:0]        cfg_data_i,
  input  logic [1:0]                         kind_i,
  input  logic [ffba_pkg::WORD_W-1:0]        request_size_i,
  input  logic [ffba_pkg::WORD_W-1:0]        payload_address_i,
  input  ffba_pkg::cmd_t                     cmd_i,
  output ffba_pkg::sts_t                     sts_o,
  output logic [1:0]                         status_o,
  output logic [ffba_pkg::WORD_W-1:0]        result_address_o,
  output logic                               moved_o,
  output logic [ffba_pkg::WORD_W-1:0]        copy_bytes_o
);

  localparam int IW = ffba_pkg::IDX_W;
  localparam int CW = ffba_pkg::CNT_W;
  localparam int W  = ffba_pkg::WORD_W;

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rd_q;

  logic [W-1:0]  base_q, limit_q, break_q;
  logic [CW-1:0] count_q, idx_q;
  logic          pv_q;
  logic [IW-1:0] cidx_q;

  logic [1:0]    kind_q;
  logic [W-1:0]  size_q, addr_q, target_q, alloc_addr_q;
  logic [IW-1:0] old_idx_q, fit_idx_q;
  ffba_pkg::entry_t old_ent_q, fit_ent_q;

  logic [1:0]    status_q;
  logic [W-1:0]  result_q, copy_q;
  logic          moved_q;

  logic          match, hit, miss, rd_en;
  logic [W-1:0]  brk;
  logic [W:0]    next_brk;
  logic          app_fail;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  ffba_pkg::entry_t wr_data;

  // scan compare: first fit or payload lookup
  always_comb begin
    if (cmd_i.scan_fit) begin
      match = rd_q.is_free && (rd_q.bytes >= size_q);
    end else begin
      match = (rd_q.start == target_q);
    end
    hit   = cmd_i.scan_en && pv_q && match;
    miss  = cmd_i.scan_en && !pv_q && (idx_q >= count_q);
    rd_en = cmd_i.scan_en && (idx_q < count_q) && !hit;
  end

  assign brk      = (count_q == '0) ? base_q : break_q;
  assign next_brk = {1'b0, brk} + (W+1)'(ffba_pkg::HEADER_BYTES) + {1'b0, size_q};
  assign app_fail = (count_q == CW'(ffba_pkg::MAX_BLOCKS)) || (next_brk > {1'b0, limit_q});

  always_comb begin
    wr_en   = cmd_i.wr_en;
    wr_idx  = old_idx_q;
    wr_data = old_ent_q;
    case (cmd_i.wr_sel)
      ffba_pkg::WR_FIT: begin
        wr_idx  = fit_idx_q;
        wr_data = '{start: fit_ent_q.start, bytes: fit_ent_q.bytes, is_free: 1'b0};
      end
      ffba_pkg::WR_OLD: begin
        wr_idx  = old_idx_q;
        wr_data = '{start: old_ent_q.start, bytes: old_ent_q.bytes, is_free: 1'b1};
      end
      ffba_pkg::WR_APPEND: begin
        wr_idx  = count_q[IW-1:0];
        wr_data = '{start: brk, bytes: size_q, is_free: 1'b0};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[IW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= '1;
      break_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ffba_pkg::CFG_HEAP_BASE:  base_q  <= cfg_data_i;
          ffba_pkg::CFG_HEAP_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0;
        pv_q  <= 1'b0;
      end else begin
        pv_q <= rd_en;
        if (rd_en) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (wr_en && (cmd_i.wr_sel == ffba_pkg::WR_APPEND)) begin
        count_q <= count_q + CW'(1);
        break_q <= next_brk[W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q   <= kind_i;
      size_q   <= request_size_i;
      addr_q   <= payload_address_i;
      target_q <= payload_address_i - W'(ffba_pkg::HEADER_BYTES);
    end
    if (rd_en) begin
      cidx_q <= idx_q[IW-1:0];
    end
    if (hit && !cmd_i.scan_fit) begin
      old_idx_q <= cidx_q;
      old_ent_q <= rd_q;
    end
    if (hit && cmd_i.scan_fit) begin
      fit_idx_q    <= cidx_q;
      fit_ent_q    <= rd_q;
      alloc_addr_q <= rd_q.start + W'(ffba_pkg::HEADER_BYTES);
    end
    if (wr_en && (cmd_i.wr_sel == ffba_pkg::WR_APPEND)) begin
      alloc_addr_q <= brk + W'(ffba_pkg::HEADER_BYTES);
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      case (cmd_i.out_src)
        ffba_pkg::SRC_ALLOC: begin
          result_q <= alloc_addr_q;
          moved_q  <= 1'b0;
          copy_q   <= '0;
        end
        ffba_pkg::SRC_SAME: begin
          result_q <= addr_q;
          moved_q  <= 1'b0;
          copy_q   <= '0;
        end
        ffba_pkg::SRC_MOVED: begin
          result_q <= alloc_addr_q;
          moved_q  <= 1'b1;
          copy_q   <= old_ent_q.bytes;
        end
        default: begin
          result_q <= '0;
          moved_q  <= 1'b0;
          copy_q   <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.addr_zero = (addr_q == '0);
    sts_o.size_zero = (size_q == '0);
    sts_o.scan_hit  = hit;
    sts_o.scan_miss = miss;
    sts_o.old_fits  = (old_ent_q.bytes >= size_q);
    sts_o.app_fail  = app_fail;
  end

  assign status_o         = status_q;
  assign result_address_o = result_q;
  assign moved_o          = moved_q;
  assign copy_bytes_o     = copy_q;

endmodule

>>> design/ffba_ctrl.sv
// Controller: sequences lookup, first-fit scan, append and table updates.
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ffba_pkg::sts_t sts_i,
  output ffba_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_FIND    = 4'd2;
  localparam logic [3:0] S_FOUND   = 4'd3;
  localparam logic [3:0] S_FREE_WR = 4'd4;
  localparam logic [3:0] S_ALLOC   = 4'd5;
  localparam logic [3:0] S_FIT     = 4'd6;
  localparam logic [3:0] S_FIT_WR  = 4'd7;
  localparam logic [3:0] S_APPEND  = 4'd8;
  localparam logic [3:0] S_POST    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] fin_status_q, fin_status_d;
  logic [1:0] fin_src_q, fin_src_d;

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = fin_status_q;
    cmd_o.out_src    = fin_src_q;
    state_d          = state_q;
    fin_status_d     = fin_status_q;
    fin_src_d        = fin_src_q;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.kind)
          ffba_pkg::KIND_ALLOC: begin
            state_d = S_ALLOC;
          end
          ffba_pkg::KIND_FREE: begin
            if (sts_i.addr_zero) begin
              fin_status_d = ffba_pkg::ST_OK;
              fin_src_d    = ffba_pkg::SRC_NONE;
              state_d      = S_FIN;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_FIND;
            end
          end
          ffba_pkg::KIND_RESIZE: begin
            if (sts_i.addr_zero) begin
              state_d = S_ALLOC;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_FIND;
            end
          end
          default: begin
            fin_status_d = ffba_pkg::ST_OK;
            fin_src_d    = ffba_pkg::SRC_NONE;
            state_d      = S_FIN;
          end
        endcase
      end
      S_FIND: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_FOUND;
        end else if (sts_i.scan_miss) begin
          fin_status_d = ffba_pkg::ST_UNKNOWN;
          fin_src_d    = ffba_pkg::SRC_NONE;
          state_d      = S_FIN;
        end
      end
      S_FOUND: begin
        if (sts_i.kind == ffba_pkg::KIND_FREE) begin
          state_d = S_FREE_WR;
        end else if (sts_i.old_fits) begin
          fin_status_d = ffba_pkg::ST_OK;
          fin_src_d    = ffba_pkg::SRC_SAME;
          state_d      = S_FIN;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_FREE_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffba_pkg::WR_OLD;
        fin_status_d = ffba_pkg::ST_OK;
        fin_src_d    = ffba_pkg::SRC_NONE;
        state_d      = S_FIN;
      end
      S_ALLOC: begin
        if (sts_i.size_zero) begin
          fin_status_d = ffba_pkg::ST_ZERO;
          fin_src_d    = ffba_pkg::SRC_NONE;
          state_d      = S_FIN;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_FIT;
        end
      end
      S_FIT: begin
        cmd_o.scan_en  = 1'b1;
        cmd_o.scan_fit = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_FIT_WR;
        end else if (sts_i.scan_miss) begin
          state_d = S_APPEND;
        end
      end
      S_FIT_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffba_pkg::WR_FIT;
        state_d      = S_POST;
      end
      S_APPEND: begin
        if (sts_i.app_fail) begin
          fin_status_d = ffba_pkg::ST_SPACE;
          fin_src_d    = ffba_pkg::SRC_NONE;
          state_d      = S_FIN;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffba_pkg::WR_APPEND;
          state_d      = S_POST;
        end
      end
      S_POST: begin
        fin_status_d = ffba_pkg::ST_OK;
        if ((sts_i.kind == ffba_pkg::KIND_RESIZE) && !sts_i.addr_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffba_pkg::WR_OLD;
          fin_src_d    = ffba_pkg::SRC_MOVED;
        end else begin
          fin_src_d = ffba_pkg::SRC_ALLOC;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      fin_status_q <= ffba_pkg::ST_OK;
      fin_src_q    <= ffba_pkg::SRC_NONE;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      fin_status_q <= fin_status_d;
      fin_src_q    <= fin_src_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> test/tb_first_fit_block_allocator.sv
// Self-checking testbench of the first-fit block allocator: random and directed requests.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  // Undefined request kind; the block answers it with an all-zero word.
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] addr;
    logic              moved;
    logic [WORD_W-1:0] copy;
  } reply_t;

  // Drive every input to a known value from time zero.
  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_valid_i       = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i       = '0;
  logic [WORD_W-1:0]    cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           kind_i            = '0;
  logic [WORD_W-1:0]    request_size_i    = '0;
  logic [WORD_W-1:0]    payload_address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i       = 1'b0;
  logic [1:0]           status_o;
  logic [WORD_W-1:0]    result_address_o;
  logic                 moved_o;
  logic [WORD_W-1:0]    copy_bytes_o;

  first_fit_block_allocator i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Heap bookkeeping: our own copy of the configuration and the block table.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] heap_base_q  = '0;
  logic [WORD_W-1:0] heap_limit_q = '1;
  logic [WORD_W-1:0] tbl_start [MAX_BLOCKS];
  logic [WORD_W-1:0] tbl_bytes [MAX_BLOCKS];
  bit                tbl_free  [MAX_BLOCKS];
  int unsigned       tbl_count = 0;
  logic [WORD_W-1:0] brk_q     = '0;

  request_t requests_queued[$];   // words waiting for the driver
  reply_t   replies_due[$];       // expected result words, oldest first
  request_t on_wire;              // word currently offered to the block
  int       words_sent  = 0;
  int       words_seen  = 0;
  int       mismatches  = 0;
  int       send_hold   = 0;
  int       recv_hold   = 0;
  bit       no_idle     = 1'b0;

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic request_t make_req(input logic [1:0] kind, input logic [WORD_W-1:0] size,
                                        input logic [WORD_W-1:0] addr);
    request_t rq;
    rq.kind = kind;
    rq.size = size;
    rq.addr = addr;
    return rq;
  endfunction

  // First fit over the table, else append at the break. Returns the status.
  function automatic logic [1:0] claim_space(input logic [WORD_W-1:0] size,
                                             output logic [WORD_W-1:0] addr);
    logic [WORD_W-1:0] hdr;
    logic [WORD_W:0]   next_brk;
    addr = '0;
    if (size == '0) return ST_ZERO;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_bytes[i] >= size) begin
        tbl_free[i] = 1'b0;
        addr = tbl_start[i] + HEADER_BYTES;
        return ST_OK;
      end
    end
    if (tbl_count >= MAX_BLOCKS) return ST_SPACE;
    hdr = (tbl_count == 0) ? heap_base_q : brk_q;
    // Keep the carry: a break that wraps past the top must fail.
    next_brk = {1'b0, hdr} + HEADER_BYTES + size;
    if (next_brk > {1'b0, heap_limit_q}) return ST_SPACE;
    tbl_start[tbl_count] = hdr;
    tbl_bytes[tbl_count] = size;
    tbl_free[tbl_count]  = 1'b0;
    addr = hdr + HEADER_BYTES;
    tbl_count++;
    brk_q = next_brk[WORD_W-1:0];
    return ST_OK;
  endfunction

  // Index of the first block with this payload address, or -1.
  function automatic int find_payload(input logic [WORD_W-1:0] addr);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] + HEADER_BYTES == addr) return i;
    end
    return -1;
  endfunction

  // Apply one request to the table and return the word the block must give back.
  function automatic reply_t heap_reply(input request_t rq);
    reply_t r;
    int     idx;
    r = '0;
    case (rq.kind)
      KIND_ALLOC: begin
        r.status = claim_space(rq.size, r.addr);
      end
      KIND_FREE: begin
        if (rq.addr != '0) begin
          idx = find_payload(rq.addr);
          if (idx < 0) r.status = ST_UNKNOWN;
          else tbl_free[idx] = 1'b1;
        end
      end
      KIND_RESIZE: begin
        if (rq.addr == '0) begin
          r.status = claim_space(rq.size, r.addr);
        end else begin
          idx = find_payload(rq.addr);
          if (idx < 0) begin
            r.status = ST_UNKNOWN;
          end else if (tbl_bytes[idx] >= rq.size) begin
            // Big enough already: same address, even for a free block.
            r.addr = rq.addr;
          end else begin
            r.status = claim_space(rq.size, r.addr);
            if (r.status == ST_OK) begin
              tbl_free[idx] = 1'b1;
              r.moved = 1'b1;
              r.copy  = tbl_bytes[idx];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random request; free and resize mostly aim at blocks known at round start.
  function automatic request_t random_request();
    request_t    rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    rq.kind = (pick < 40) ? KIND_ALLOC : (pick < 68) ? KIND_FREE :
              (pick < 95) ? KIND_RESIZE : KIND_NONE;
    pick = $urandom_range(0, 99);
    rq.size = (pick < 8)  ? '0 :
              (pick < 70) ? WORD_W'($urandom_range(1, 64)) :
              (pick < 90) ? WORD_W'($urandom_range(65, 400)) : WORD_W'($urandom);
    pick = $urandom_range(0, 99);
    if (tbl_count != 0 && pick < 72) begin
      rq.addr = tbl_start[$urandom_range(0, tbl_count - 1)] + HEADER_BYTES;
    end else if (pick < 82) begin
      rq.addr = '0;
    end else if (tbl_count != 0 && pick < 90) begin
      // Near miss: one to eight bytes past a block's payload start.
      rq.addr = tbl_start[$urandom_range(0, tbl_count - 1)] + HEADER_BYTES
                + $urandom_range(1, 8);
    end else begin
      rq.addr = $urandom;
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued words with random gaps; predict each accepted word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_hold = draw_gap();
    end else begin
      if (in_valid_i && in_ready_o) begin
        replies_due.push_back(heap_reply(on_wire));
      end
      // Hold the word while it waits for ready; otherwise advance.
      if (!in_valid_i || in_ready_o) begin
        if (send_hold != 0) begin
          send_hold--;
          in_valid_i <= 1'b0;
        end else if (requests_queued.size() != 0) begin
          on_wire = requests_queued.pop_front();
          in_valid_i        <= 1'b1;
          kind_i            <= on_wire.kind;
          request_size_i    <= on_wire.size;
          payload_address_i <= on_wire.addr;
          words_sent++;
          send_hold = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result side at random and compare each word in order.
  // ---------------------------------------------------------------------------
  reply_t got_word;
  reply_t due_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_hold = draw_gap();
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        got_word = {status_o, result_address_o, moved_o, copy_bytes_o};
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] result word with nothing expected: status %0d addr %h moved %0d copy %h",
                     $realtime, got_word.status, got_word.addr, got_word.moved, got_word.copy);
        end else begin
          due_word = replies_due.pop_front();
          if (got_word.status !== due_word.status || got_word.addr !== due_word.addr ||
              got_word.moved !== due_word.moved || got_word.copy !== due_word.copy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("[%0t] mismatch: expected status %0d addr %h moved %0d copy %h, got status %0d addr %h moved %0d copy %h",
                       $realtime, due_word.status, due_word.addr, due_word.moved,
                       due_word.copy, got_word.status, got_word.addr, got_word.moved,
                       got_word.copy);
          end
        end
        recv_hold = draw_gap();
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers.
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [WORD_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == CFG_HEAP_BASE) heap_base_q = value;
    else heap_limit_q = value;
  endtask

  // Wait until every queued word went out and every answer came back.
  task automatic wait_drained();
    while (requests_queued.size() != 0 || words_sent != words_seen) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Rounds of random words; drain between rounds so fresh blocks become targets.
  task automatic run_rounds(input int rounds, input int per_round, input int calm_pct);
    for (int r = 0; r < rounds; r++) begin
      no_idle = ($urandom_range(0, 99) < calm_pct);
      for (int n = 0; n < per_round; n++) requests_queued.push_back(random_request());
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       widest;
    logic [WORD_W-1:0] huge;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: base 0, limit all ones, empty table.
    requests_queued.push_back(make_req(KIND_ALLOC,  '0,              '0));
    requests_queued.push_back(make_req(KIND_FREE,   '0,              '0));
    requests_queued.push_back(make_req(KIND_FREE,   32'd5,           32'd24));
    requests_queued.push_back(make_req(KIND_RESIZE, '0,              '0));
    requests_queued.push_back(make_req(KIND_NONE,   32'hFFFF_FFFF,   32'hFFFF_FFFF));
    requests_queued.push_back(make_req(KIND_ALLOC,  32'd16,          '0));     // header at base
    requests_queued.push_back(make_req(KIND_ALLOC,  32'hFFFF_FFFF,   '0));     // past limit
    requests_queued.push_back(make_req(KIND_ALLOC,  32'd100,         '0));
    requests_queued.push_back(make_req(KIND_RESIZE, 32'd8,           32'd24)); // fits
    requests_queued.push_back(make_req(KIND_RESIZE, '0,              32'd24)); // zero fits
    requests_queued.push_back(make_req(KIND_RESIZE, 32'd200,         32'd24)); // moves
    requests_queued.push_back(make_req(KIND_FREE,   '0,              32'd24)); // already free
    requests_queued.push_back(make_req(KIND_ALLOC,  32'd10,          '0));     // reuse first
    requests_queued.push_back(make_req(KIND_FREE,   '0,              32'd64));
    requests_queued.push_back(make_req(KIND_RESIZE, 32'd50,          32'd64)); // free block fits
    requests_queued.push_back(make_req(KIND_RESIZE, 32'hFFFF_FFFF,   32'd64)); // cannot grow
    requests_queued.push_back(make_req(KIND_FREE,   '0,              32'd25));
    requests_queued.push_back(make_req(KIND_RESIZE, 32'd1,           32'hFFFF_FFFF));
    requests_queued.push_back(make_req(KIND_ALLOC,  32'd100,         '0));
    requests_queued.push_back(make_req(KIND_ALLOC,  32'd100,         '0));
    requests_queued.push_back(make_req(KIND_RESIZE, 32'd30,          '0));     // acts as alloc
    requests_queued.push_back(make_req(KIND_RESIZE, 32'hFFFF_FFFF,   '0));
    wait_drained();

    // Move the base under a live table (break must stay) and leave little room.
    write_register(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_register(CFG_HEAP_LIMIT, brk_q + 32'd600);
    run_rounds(4, 40, 25);

    // Limit at zero: every append fails, reuse still works; no idling here.
    write_register(CFG_HEAP_LIMIT, '0);
    write_register(CFG_HEAP_BASE, '0);
    run_rounds(3, 35, 100);

    // Fill the table with blocks wider than any free one, leaving two slots.
    write_register(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    widest = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_bytes[i] > widest) widest = tbl_bytes[i];
    end
    for (int i = tbl_count; i < MAX_BLOCKS - 2; i++) begin
      requests_queued.push_back(make_req(KIND_ALLOC, widest + 1, '0));
    end
    wait_drained();

    // Push the break near the top, then try a size whose sum would wrap.
    huge = 32'hFFFF_F000 - brk_q - HEADER_BYTES;
    requests_queued.push_back(make_req(KIND_ALLOC, huge,        '0));
    requests_queued.push_back(make_req(KIND_ALLOC, 32'h2000,    '0));
    requests_queued.push_back(make_req(KIND_ALLOC, widest + 1,  '0));  // last slot
    requests_queued.push_back(make_req(KIND_ALLOC, widest + 1,  '0));  // table full
    wait_drained();

    write_register(CFG_HEAP_BASE, $urandom);
    write_register(CFG_HEAP_LIMIT, $urandom);
    run_rounds(5, 40, 25);

    repeat (100) @(posedge clk_i);
    mismatches += replies_due.size();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
